### hw/rtl/shtqp_pkg.sv
package shtqp_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_FOUND       = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_INSERTED    = 3'd2,
        ST_FULL        = 3'd3,
        ST_TOO_LONG    = 3'd4,
        ST_PROBE_LIMIT = 3'd5
    } t_status;

    // Operation selector.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_RDUSED,
        S_CHKUSED,
        S_RDLEN,
        S_CMPLEN,
        S_RDBYTE,
        S_CMPBYTE,
        S_WRBYTE,
        S_NEXT,
        S_DONE
    } t_state;

    localparam int unsigned HASH_MULT = 31;
    localparam int unsigned CH_W      = 7;
    localparam int unsigned STATUS_W  = 3;
    // Slot count of the table; a power of two so the slot index is the low hash bits.
    localparam int unsigned N_SLOTS   = 1024;
    localparam int unsigned SLOT_W    = $clog2(N_SLOTS);

endpackage

### hw/rtl/string_hash_table_quadratic_probe_unit.sv
// Channel | Dir | tdata (low bit up)         | tuser | tlast
// s_axis  | in  | ch[6:0], pad               | op    | last
// m_axis  | out | status[2:0], slot[12:3]    | -     | -
//
// Every byte is accepted in S_IDLE and then folded into the hash in S_HASH.
// A last byte starts the probe walk at the low hash bits. An insert probe reads and checks
// the used bit; a search probe also reads and compares the length, then each byte in turn;
// an insert then writes one byte per cycle, and S_DONE hands the result to the output register.
// After reset a clearing pass over all N_SLOTS (1024) slots empties the used bits; no beat
// is taken meanwhile. A waiting result stalls the block only when the next walk ends.
module string_hash_table_quadratic_probe_unit #(
    parameter int unsigned MAX_LEN    = 16,
    parameter int unsigned MAX_PROBES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // ch[6:0], zero pad
    input  logic       s_axis_tuser,   // op
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[2:0], slot[12:3], zero pad
);

    localparam int unsigned NS  = shtqp_pkg::N_SLOTS;
    localparam int unsigned IW  = shtqp_pkg::SLOT_W;
    localparam int unsigned LW  = $clog2(MAX_LEN + 1);
    localparam int unsigned BW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned PW  = $clog2(MAX_PROBES + 1);
    localparam int unsigned CW  = $clog2(NS + 1);
    localparam int unsigned DEP = NS * MAX_LEN;
    localparam int unsigned AW  = $clog2(DEP);

    // Memories.
    logic [6:0]    m_bytes [DEP];
    logic [LW-1:0] m_len   [NS];
    logic          m_used  [NS];
    logic [6:0]    r_wbuf  [MAX_LEN];

    shtqp_pkg::t_state r_state, n_state;
    logic [31:0]   r_hash;
    logic [LW-1:0] r_wlen;
    logic          r_over, r_op;
    logic [6:0]    r_ch;
    logic          r_last;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_sq;
    logic [PW-1:0] r_att;
    logic [LW-1:0] r_k;
    logic [CW-1:0] r_count;
    logic          r_used_q;
    logic [LW-1:0] r_len_q;
    logic [6:0]    r_byte_q;
    logic [2:0]    r_stat;
    logic [IW-1:0] r_slot;
    logic          r_ovalid;
    logic [2:0]    r_ostat;
    logic [IW-1:0] r_oslot;

    assign s_axis_tready = (r_state == shtqp_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_oslot, r_ostat};

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // The finished walk moves into the output register once it is free or being taken.
    logic w_load;
    assign w_load = (r_state == shtqp_pkg::S_DONE) && (!r_ovalid || m_axis_tready);

    // Next hash value.
    logic [31:0] w_hash_next;
    assign w_hash_next = r_hash * 32'(shtqp_pkg::HASH_MULT) + 32'(r_ch);

    // Probe step: (a+1)^2 = a^2 + 2a + 1, all modulo the slot count.
    logic [IW-1:0] w_att_lo;
    logic [IW-1:0] w_sq_next;
    logic [IW-1:0] w_idx_next;
    assign w_att_lo   = IW'(r_att);
    assign w_sq_next  = r_sq + {w_att_lo[IW-2:0], 1'b1};
    assign w_idx_next = r_idx + w_sq_next;

    // Byte address of the current slot and byte position.
    logic [AW-1:0] w_baddr;
    assign w_baddr = AW'(r_idx) * AW'(MAX_LEN) + AW'(r_k);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shtqp_pkg::S_CLEAR:   if (r_idx == IW'(NS - 1)) n_state = shtqp_pkg::S_IDLE;
            shtqp_pkg::S_IDLE:    if (acc) n_state = shtqp_pkg::S_HASH;
            shtqp_pkg::S_HASH: begin
                if (!r_last) n_state = shtqp_pkg::S_IDLE;
                else if (r_over) n_state = shtqp_pkg::S_DONE;
                else if (r_op == shtqp_pkg::OP_INSERT && r_count >= CW'(NS))
                    n_state = shtqp_pkg::S_DONE;
                else n_state = shtqp_pkg::S_RDUSED;
            end
            shtqp_pkg::S_RDUSED:  n_state = shtqp_pkg::S_CHKUSED;
            shtqp_pkg::S_CHKUSED: begin
                if (!r_used_q)
                    n_state = (r_op == shtqp_pkg::OP_SEARCH) ? shtqp_pkg::S_DONE
                                                            : shtqp_pkg::S_WRBYTE;
                else if (r_op == shtqp_pkg::OP_SEARCH) n_state = shtqp_pkg::S_RDLEN;
                else n_state = shtqp_pkg::S_NEXT;
            end
            shtqp_pkg::S_RDLEN:   n_state = shtqp_pkg::S_CMPLEN;
            shtqp_pkg::S_CMPLEN: begin
                if (r_len_q != r_wlen) n_state = shtqp_pkg::S_NEXT;
                else if (r_wlen == '0) n_state = shtqp_pkg::S_DONE;
                else n_state = shtqp_pkg::S_RDBYTE;
            end
            shtqp_pkg::S_RDBYTE:  n_state = shtqp_pkg::S_CMPBYTE;
            shtqp_pkg::S_CMPBYTE: begin
                if (r_byte_q != r_wbuf[r_k[BW-1:0]]) n_state = shtqp_pkg::S_NEXT;
                else if (r_k + 1'b1 == r_wlen) n_state = shtqp_pkg::S_DONE;
                else n_state = shtqp_pkg::S_RDBYTE;
            end
            shtqp_pkg::S_WRBYTE:  if (r_k + 1'b1 >= r_wlen) n_state = shtqp_pkg::S_DONE;
            shtqp_pkg::S_NEXT:    n_state = (r_att + 1'b1 >= PW'(MAX_PROBES))
                                      ? shtqp_pkg::S_DONE : shtqp_pkg::S_RDUSED;
            shtqp_pkg::S_DONE:    if (w_load) n_state = shtqp_pkg::S_IDLE;
            default:              n_state = shtqp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= shtqp_pkg::S_CLEAR;
        else          r_state <= n_state;
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (r_state == shtqp_pkg::S_CLEAR) m_used[r_idx] <= 1'b0;
        else if (r_state == shtqp_pkg::S_WRBYTE && n_state == shtqp_pkg::S_DONE)
            m_used[r_idx] <= 1'b1;
        r_used_q <= m_used[r_idx];
        if (r_state == shtqp_pkg::S_WRBYTE && n_state == shtqp_pkg::S_DONE)
            m_len[r_idx] <= r_wlen;
        r_len_q <= m_len[r_idx];
        if (r_state == shtqp_pkg::S_WRBYTE && r_k < r_wlen)
            m_bytes[w_baddr] <= r_wbuf[r_k[BW-1:0]];
        r_byte_q <= m_bytes[w_baddr];
        if (acc && r_wlen < LW'(MAX_LEN)) r_wbuf[r_wlen[BW-1:0]] <= s_axis_tdata[6:0];
    end

    // Datapath and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_hash   <= '0;
            r_wlen   <= '0;
            r_over   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_ostat  <= '0;
            r_oslot  <= '0;
        end else begin
            unique case (r_state)
                shtqp_pkg::S_CLEAR: r_idx <= r_idx + 1'b1;
                shtqp_pkg::S_IDLE: if (acc) begin
                    r_ch   <= s_axis_tdata[6:0];
                    r_op   <= s_axis_tuser;
                    r_last <= s_axis_tlast;
                    if (r_wlen < LW'(MAX_LEN)) r_wlen <= r_wlen + 1'b1;
                    else r_over <= 1'b1;
                end
                shtqp_pkg::S_HASH: begin
                    r_hash <= w_hash_next;
                    r_idx  <= w_hash_next[IW-1:0];
                    r_sq   <= '0;
                    r_att  <= '0;
                    r_k    <= '0;
                    r_stat <= r_over ? shtqp_pkg::ST_TOO_LONG : shtqp_pkg::ST_FULL;
                    r_slot <= '0;
                end
                shtqp_pkg::S_CHKUSED: begin
                    r_k <= '0;
                    if (!r_used_q && r_op == shtqp_pkg::OP_SEARCH)
                        r_stat <= shtqp_pkg::ST_NOT_FOUND;
                end
                shtqp_pkg::S_CMPLEN:
                    if (r_len_q == r_wlen && r_wlen == '0) begin
                        r_stat <= shtqp_pkg::ST_FOUND;
                        r_slot <= r_idx;
                    end
                shtqp_pkg::S_CMPBYTE: begin
                    r_k <= r_k + 1'b1;
                    if (r_byte_q == r_wbuf[r_k[BW-1:0]] && r_k + 1'b1 == r_wlen) begin
                        r_stat <= shtqp_pkg::ST_FOUND;
                        r_slot <= r_idx;
                    end
                end
                shtqp_pkg::S_WRBYTE: begin
                    r_k <= r_k + 1'b1;
                    if (n_state == shtqp_pkg::S_DONE) begin
                        r_stat  <= shtqp_pkg::ST_INSERTED;
                        r_slot  <= r_idx;
                        r_count <= r_count + 1'b1;
                    end
                end
                shtqp_pkg::S_NEXT: begin
                    r_k   <= '0;
                    r_att <= r_att + 1'b1;
                    if (r_att + 1'b1 >= PW'(MAX_PROBES)) r_stat <= shtqp_pkg::ST_PROBE_LIMIT;
                    else begin
                        r_sq  <= w_sq_next;
                        r_idx <= w_idx_next;
                    end
                end
                shtqp_pkg::S_DONE: begin
                    r_hash <= '0;
                    r_wlen <= '0;
                    r_over <= 1'b0;
                end
                default: ;
            endcase
            // Output register.
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_ostat  <= r_stat;
                r_oslot  <= r_slot;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Checks.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == shtqp_pkg::S_IDLE))
        else $error("accept outside idle");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shtqp_pkg::S_DONE) |=> m_axis_tvalid)
        else $error("result not presented");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NS))
        else $error("entry count overflow");

endmodule

### bench/string_hash_table_quadratic_probe_unit_tb.sv
module string_hash_table_quadratic_probe_unit_tb;

    localparam int unsigned TBL     = 1024;
    localparam int unsigned WLEN    = 16;
    localparam int unsigned PROBES  = 32;
    localparam int unsigned N_RAND  = 1050;
    localparam longint      LIMIT   = 10000000;

    typedef struct packed {
        shtqp_pkg::t_status status;
        logic [9:0]         slot;
    } t_answer;

    typedef struct {
        logic [6:0]         ch;
        shtqp_pkg::t_op     op;
        logic               last;
        logic               has_exp;
        shtqp_pkg::t_status exp_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // ch[6:0], zero pad
    logic        s_axis_tuser;   // op
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // status[2:0], slot[12:3], zero pad

    // Shadow copy of the dictionary.
    logic [6:0]  dict_bytes [TBL][WLEN];
    int unsigned dict_len   [TBL];
    bit          dict_used  [TBL];
    int unsigned dict_count;
    logic [6:0]  word_chars [WLEN];
    int unsigned word_len;
    logic [31:0] word_hash;
    bit          word_overlong;

    t_answer     answers_due[$];
    int          fail_count;
    longint      cycle_count;
    bit          long_stall;
    bit          stim_done;

    // Words used so far, so that searches often hit stored words.
    string       known_words[$];

    string_hash_table_quadratic_probe_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Runs the probe walk on the buffered word and updates the shadow table.
    function automatic t_answer dict_probe(shtqp_pkg::t_op op);
        t_answer     ans;
        int unsigned idx;
        int unsigned tries;
        bit          same;
        ans.slot = '0;
        idx = word_hash % TBL;
        tries = 0;
        if (op == shtqp_pkg::OP_INSERT && dict_count >= TBL) begin
            ans.status = shtqp_pkg::ST_FULL;
            return ans;
        end
        forever begin
            if (!dict_used[idx]) begin
                if (op == shtqp_pkg::OP_SEARCH) begin
                    ans.status = shtqp_pkg::ST_NOT_FOUND;
                    return ans;
                end
                for (int k = 0; k < word_len; k++) dict_bytes[idx][k] = word_chars[k];
                dict_len[idx] = word_len;
                dict_used[idx] = 1'b1;
                dict_count++;
                ans.status = shtqp_pkg::ST_INSERTED;
                ans.slot = idx[9:0];
                return ans;
            end
            if (op == shtqp_pkg::OP_SEARCH && dict_len[idx] == word_len) begin
                same = 1'b1;
                for (int k = 0; k < word_len; k++)
                    if (dict_bytes[idx][k] != word_chars[k]) same = 1'b0;
                if (same) begin
                    ans.status = shtqp_pkg::ST_FOUND;
                    ans.slot = idx[9:0];
                    return ans;
                end
            end
            tries++;
            if (tries >= PROBES) begin
                ans.status = shtqp_pkg::ST_PROBE_LIMIT;
                return ans;
            end
            idx = (idx + tries * tries) % TBL;
        end
    endfunction

    // Folds one accepted beat into the word and queues the answer on the last one.
    function automatic void dict_take_beat(logic [6:0] ch, shtqp_pkg::t_op op, logic last);
        t_answer ans;
        word_hash = word_hash * shtqp_pkg::HASH_MULT + 32'(ch);
        if (word_len < WLEN) begin
            word_chars[word_len] = ch;
            word_len++;
        end else begin
            word_overlong = 1'b1;
        end
        if (last) begin
            if (word_overlong) begin
                ans.status = shtqp_pkg::ST_TOO_LONG;
                ans.slot = '0;
            end else begin
                ans = dict_probe(op);
            end
            answers_due.push_back(ans);
            word_len = 0;
            word_hash = '0;
            word_overlong = 1'b0;
        end
    endfunction

    // Offers one beat and returns at the edge that takes it.
    task automatic drive_beat(logic [6:0] ch, shtqp_pkg::t_op op, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ch};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Offers one beat, waits until it is taken and updates the predictor.
    task automatic send_beat(logic [6:0] ch, shtqp_pkg::t_op op, logic last);
        drive_beat(ch, op, last);
        dict_take_beat(ch, op, last);
        @(negedge i_clk);
    endtask

    // Drops valid for a random gap now and then, giving bursts.
    task automatic sender_gap();
        int gap;
        if ($urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_word(string w, shtqp_pkg::t_op op);
        byte b;
        for (int i = 0; i < w.len(); i++) begin
            b = w[i];
            sender_gap();
            send_beat(b[6:0], op, i == w.len() - 1);
        end
    endtask

    function automatic string rand_word(int unsigned n, int unsigned alpha);
        string w;
        byte   b;
        w = "";
        for (int i = 0; i < n; i++) begin
            b = (alpha == 0) ? byte'($urandom_range(1, 127))
                             : byte'($urandom_range(97, 97 + alpha - 1));
            w = {w, string'(b)};
        end
        return w;
    endfunction

    // Directed rows; expected status filled in only for the obvious cases.
    t_row rows[$];

    function automatic void add_row(logic [6:0] ch, shtqp_pkg::t_op op, logic last,
                                    logic has_exp, shtqp_pkg::t_status st);
        t_row r;
        r.ch = ch; r.op = op; r.last = last; r.has_exp = has_exp; r.exp_status = st;
        rows.push_back(r);
    endfunction

    // Sender.
    initial begin
        string w;
        int    nbeats;
        bit    stall_started;
        bit    pause_done;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        stim_done     = 1'b0;
        long_stall    = 1'b0;
        stall_started = 1'b0;
        pause_done    = 1'b0;
        fail_count    = 0;
        dict_count    = 0;
        word_len      = 0;
        word_hash     = '0;
        word_overlong = 1'b0;
        foreach (dict_used[i]) dict_used[i] = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Search on an empty table, one-char words at the extremes, zero char.
        add_row(7'h01, shtqp_pkg::OP_SEARCH, 1'b1, 1'b1, shtqp_pkg::ST_NOT_FOUND);
        add_row(7'h7F, shtqp_pkg::OP_INSERT, 1'b1, 1'b1, shtqp_pkg::ST_INSERTED);
        add_row(7'h7F, shtqp_pkg::OP_SEARCH, 1'b1, 1'b1, shtqp_pkg::ST_FOUND);
        add_row(7'h00, shtqp_pkg::OP_INSERT, 1'b1, 1'b1, shtqp_pkg::ST_INSERTED);
        add_row(7'h00, shtqp_pkg::OP_SEARCH, 1'b1, 1'b1, shtqp_pkg::ST_FOUND);
        // Duplicate insert, op taken only from the last beat.
        add_row(7'h7F, shtqp_pkg::OP_SEARCH, 1'b0, 1'b0, shtqp_pkg::ST_FOUND);
        add_row(7'h2A, shtqp_pkg::OP_INSERT, 1'b1, 1'b0, shtqp_pkg::ST_FOUND);
        add_row(7'h7F, shtqp_pkg::OP_INSERT, 1'b1, 1'b1, shtqp_pkg::ST_INSERTED);
        // Overlong word: seventeen characters.
        for (int i = 0; i < 16; i++)
            add_row(7'h55, shtqp_pkg::OP_INSERT, 1'b0, 1'b0, shtqp_pkg::ST_FOUND);
        add_row(7'h2A, shtqp_pkg::OP_INSERT, 1'b1, 1'b1, shtqp_pkg::ST_TOO_LONG);

        foreach (rows[i]) begin
            sender_gap();
            if (rows[i].has_exp) begin
                // The predictor queues its answer first; the typed status must agree.
                dict_take_beat(rows[i].ch, rows[i].op, rows[i].last);
                if (answers_due[$].status != rows[i].exp_status) begin
                    $display("%0t directed row %0d: expected %s, actual %s",
                             $time, i, rows[i].exp_status.name(),
                             answers_due[$].status.name());
                    fail_count++;
                end
                drive_beat(rows[i].ch, rows[i].op, rows[i].last);
                @(negedge i_clk);
            end else begin
                send_beat(rows[i].ch, rows[i].op, rows[i].last);
            end
        end

        // Random words: mostly short lowercase words so collisions and hits occur.
        nbeats = 0;
        while (nbeats < N_RAND) begin
            if (nbeats >= 300 && !stall_started) begin
                stall_started = 1'b1;
                long_stall    = 1'b1;
            end
            if (nbeats >= 600 && !pause_done) begin
                pause_done = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (answers_due.size() != 0) @(negedge i_clk);
            end
            case ($urandom_range(0, 9))
                0: w = rand_word($urandom_range(1, 16), 0);
                1: w = rand_word($urandom_range(17, 20), 2);
                2, 3, 4: begin
                    if (known_words.size() > 0)
                        w = known_words[$urandom_range(0, known_words.size() - 1)];
                    else
                        w = rand_word(2, 3);
                end
                default: w = rand_word($urandom_range(1, 4), 3);
            endcase
            if (w.len() <= WLEN) known_words.push_back(w);
            send_word(w, $urandom_range(0, 1) ? shtqp_pkg::OP_SEARCH
                                              : shtqp_pkg::OP_INSERT);
            nbeats += w.len();
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall pattern, plus one long hold-off while the sender keeps going.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_stall) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_stall = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Checks each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = shtqp_pkg::t_status'(m_axis_tdata[2:0]);
            got.slot   = m_axis_tdata[12:3];
            if (answers_due.size() == 0) begin
                $display("%0t unexpected result: status %0d slot %0d",
                         $time, got.status, got.slot);
                fail_count++;
            end else begin
                exp = answers_due.pop_front();
                if (got.status != exp.status) begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, exp.status, got.status);
                    fail_count++;
                end
                if (got.slot != exp.slot) begin
                    $display("%0t slot mismatch: expected %0d, actual %0d",
                             $time, exp.slot, got.slot);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("string_hash_table_quadratic_probe_unit_tb: FAIL");
        $finish;
    end

    // End of run.
    initial begin
        wait (stim_done);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && answers_due.size() == 0) begin
            $display("string_hash_table_quadratic_probe_unit_tb: PASS");
        end else begin
            $display("string_hash_table_quadratic_probe_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
